// ----- hdl/fcs_pkg.sv -----
package fcs_pkg;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int REPLY_DATA_BYTES = 6;
    localparam int REPLY_BYTES      = 8;

    localparam logic [7:0]  CRC8_POLY  = 8'h31;
    localparam logic [7:0]  CRC8_INIT  = 8'hFF;
    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;

    localparam logic [3:0] DEV_ADDR_RESET = 4'd1;
    localparam logic [7:0] TIMEOUT_RESET  = 8'd10;

    // configuration register indexes
    localparam logic CFG_OWN_ADDR      = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    // command nibble
    localparam logic [3:0] CMD_REPORT      = 4'h1;
    localparam logic [3:0] CMD_SET_LEDS    = 4'h2;
    localparam logic [3:0] CMD_CLEAR_ERROR = 4'hF;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_COMMAND = 3'd6;
    localparam logic [2:0] LERR_MAX        = 3'd4;

    typedef enum logic [2:0] {
        OP_RX_BYTE    = 3'd0,
        OP_TICK       = 3'd1,
        OP_LINE_ERROR = 3'd2,
        OP_SET_TEMP   = 3'd3,
        OP_SET_VOLT   = 3'd4,
        OP_SET_BUTTON = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        POS_IDLE  = 2'd0,
        POS_BYTE1 = 2'd1,
        POS_BYTE2 = 2'd2
    } t_frame_pos;

    // reply payload handed from front to back: six data bytes plus LED state
    typedef struct packed {
        logic [REPLY_DATA_BYTES-1:0][7:0] data;
        logic [3:0]                       leds;
    } t_reply;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC8_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- hdl/fcs_fifo.sv -----
module fcs_fifo import fcs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_reply       i_data,
    input  logic         i_pop,
    output t_reply       o_data,
    output t_fifo_status o_status
);

    t_reply            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    logic do_push, do_pop;

    assign o_status.full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/fcs_front.sv -----
module fcs_front import fcs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [2:0]   i_operation,
    input  logic [7:0]   i_rx_byte,
    input  logic [2:0]   i_line_error,
    input  logic [15:0]  i_temperature,
    input  logic [15:0]  i_voltage,
    input  logic         i_button,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    output logic         o_push,
    output t_reply       o_reply
);

    t_frame_pos r_pos, n_pos;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_second, n_second;
    logic [7:0]  r_crc8, n_crc8;
    logic [7:0]  r_stall_cnt, n_stall_cnt;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_volt, n_volt;
    logic [3:0]  r_leds, n_leds;
    logic        r_button, n_button;
    logic [2:0]  r_err, n_err;
    logic [3:0]  r_dev_addr;
    logic [7:0]  r_timeout;

    logic [7:0] stall_inc;

    assign stall_inc = r_stall_cnt + 8'd1;

    always_comb begin
        n_pos       = r_pos;
        n_first     = r_first;
        n_second    = r_second;
        n_crc8      = r_crc8;
        n_stall_cnt = r_stall_cnt;
        n_temp      = r_temp;
        n_volt      = r_volt;
        n_leds      = r_leds;
        n_button    = r_button;
        n_err       = r_err;
        o_push      = 1'b0;
        if (i_accept) begin
            case (t_op'(i_operation))
                OP_RX_BYTE: begin
                    case (r_pos)
                        POS_IDLE: begin
                            n_first = i_rx_byte;
                            n_crc8  = crc8_byte(CRC8_INIT, i_rx_byte);
                            n_pos   = POS_BYTE1;
                        end
                        POS_BYTE1: begin
                            n_second = i_rx_byte;
                            n_crc8   = crc8_byte(r_crc8, i_rx_byte);
                            n_pos    = POS_BYTE2;
                        end
                        default: begin
                            n_pos = POS_IDLE;
                            if (r_first[3:0] == r_dev_addr && r_crc8 == i_rx_byte) begin
                                o_push = 1'b1;
                                case (r_first[7:4])
                                    CMD_REPORT:      ;
                                    CMD_SET_LEDS:    n_leds = r_second[3:0];
                                    CMD_CLEAR_ERROR: n_err  = ERR_NONE;
                                    default:         n_err  = ERR_BAD_COMMAND;
                                endcase
                            end
                        end
                    endcase
                end
                OP_TICK: begin
                    if (r_pos == POS_IDLE) begin
                        n_stall_cnt = '0;
                    end else if (stall_inc >= r_timeout) begin
                        n_stall_cnt = '0;
                        n_pos       = POS_IDLE;
                    end else begin
                        n_stall_cnt = stall_inc;
                    end
                end
                OP_LINE_ERROR: begin
                    n_pos = POS_IDLE;
                    if (i_line_error <= LERR_MAX) begin
                        n_err = i_line_error + 3'd1;
                    end
                end
                OP_SET_TEMP:   n_temp   = i_temperature;
                OP_SET_VOLT:   n_volt   = i_voltage;
                OP_SET_BUTTON: n_button = i_button;
                default: ;
            endcase
        end
    end

    // reply snapshot reflects the state after the command
    always_comb begin
        o_reply.data[0] = n_temp[7:0];
        o_reply.data[1] = n_temp[15:8];
        o_reply.data[2] = n_volt[7:0];
        o_reply.data[3] = n_volt[15:8];
        o_reply.data[4] = {3'b000, n_button, n_leds};
        o_reply.data[5] = {5'b00000, n_err};
        o_reply.leds    = n_leds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_IDLE;
            r_first     <= '0;
            r_second    <= '0;
            r_crc8      <= '0;
            r_stall_cnt <= '0;
            r_temp      <= '0;
            r_volt      <= '0;
            r_leds      <= '0;
            r_button    <= 1'b0;
            r_err       <= ERR_NONE;
            r_dev_addr  <= DEV_ADDR_RESET;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            r_pos       <= n_pos;
            r_first     <= n_first;
            r_second    <= n_second;
            r_crc8      <= n_crc8;
            r_stall_cnt <= n_stall_cnt;
            r_temp      <= n_temp;
            r_volt      <= n_volt;
            r_leds      <= n_leds;
            r_button    <= n_button;
            r_err       <= n_err;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OWN_ADDR:      r_dev_addr <= i_cfg_data[3:0];
                    CFG_TIMEOUT_TICKS: r_timeout  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- hdl/fcs_back.sv -----
module fcs_back import fcs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_reply       i_reply,
    input  t_fifo_status i_status,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [7:0]   o_tx_byte,
    output logic         o_last,
    output logic [3:0]   o_leds
);

    localparam logic [2:0] IDX_CRC_LO = 3'(REPLY_DATA_BYTES);
    localparam logic [2:0] IDX_LAST   = 3'(REPLY_BYTES - 1);

    logic        r_valid;
    logic [7:0]  r_tx_byte;
    logic        r_last;
    logic [3:0]  r_leds;
    logic [2:0]  r_idx;
    logic [15:0] r_crc;

    logic       load;
    logic [7:0] sel_byte;
    logic [15:0] crc_base;

    assign load     = !i_status.empty && (!r_valid || !i_stall);
    assign o_pop    = load && (r_idx == IDX_LAST);
    assign crc_base = (r_idx == 3'd0) ? CRC16_INIT : r_crc;

    always_comb begin
        case (r_idx)
            3'd0:    sel_byte = i_reply.data[0];
            3'd1:    sel_byte = i_reply.data[1];
            3'd2:    sel_byte = i_reply.data[2];
            3'd3:    sel_byte = i_reply.data[3];
            3'd4:    sel_byte = i_reply.data[4];
            3'd5:    sel_byte = i_reply.data[5];
            3'd6:    sel_byte = r_crc[7:0];
            default: sel_byte = r_crc[15:8];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tx_byte <= sel_byte;
            r_last    <= (r_idx == IDX_LAST);
            r_leds    <= i_reply.leds;
            if (r_idx < IDX_CRC_LO) begin
                r_crc <= crc16_byte(crc_base, sel_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= r_idx + 3'd1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid   = r_valid;
    assign o_tx_byte = r_tx_byte;
    assign o_last    = r_last;
    assign o_leds    = r_leds;

endmodule

// ----- hdl/framed_command_slave.sv -----
// A good frame's reply is pushed into the reply queue, then loaded into the output byte register.
// Items come in one per cycle while the reply queue is not full; a reply streams out one
// byte per cycle while the queue holds it and the receiver does not stall, eight bytes per reply.
// Input stalls only while the two-entry reply queue is full.
// Reset (i_rst_n low, synchronous) clears frame state, held readings, LEDs, error code,
// the reply queue and the output; the own address returns to 1, the timeout to 10 ticks.
module framed_command_slave import fcs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_operation,
    input  logic [7:0]         i_rx_byte,
    input  logic [2:0]         i_line_error,
    input  logic signed [15:0] i_temperature,
    input  logic [15:0]        i_voltage,
    input  logic               i_button,
    // reply byte channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_tx_byte,
    output logic               o_last,
    output logic [3:0]         o_leds,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    t_reply       front_reply, head_reply;
    t_fifo_status q_status;
    logic         push, pop;
    logic         accept;

    // Front keeps the frame assembler and all held state; every item waits
    // while the reply queue is full.
    assign o_stall = q_status.full;
    assign accept  = i_valid && !o_stall;

    fcs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_operation   (i_operation),
        .i_rx_byte     (i_rx_byte),
        .i_line_error  (i_line_error),
        .i_temperature (16'(unsigned'(i_temperature))),
        .i_voltage     (i_voltage),
        .i_button      (i_button),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (push),
        .o_reply       (front_reply)
    );

    // Short queue of reply snapshots between front and back.
    fcs_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_reply),
        .i_pop    (pop),
        .o_data   (head_reply),
        .o_status (q_status)
    );

    // Back streams each reply, folding bytes into the CRC-16 as they go out.
    fcs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reply   (head_reply),
        .i_status  (q_status),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_tx_byte (o_tx_byte),
        .o_last    (o_last),
        .o_leds    (o_leds)
    );

endmodule

// ----- dv/fcs_reply_checker.sv -----
package fcs_tb_pkg;

    import fcs_pkg::*;

    // one reply byte as seen on the output channel
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic [3:0] leds;
    } t_reply_byte;

    // CRC-8 over the two leading frame bytes, bit-serial, MSB first
    function automatic logic [7:0] frame_crc8(input logic [7:0] b0, input logic [7:0] b1);
        logic [15:0] stream;
        logic [7:0]  r;
        logic        fb;
        int          i;
        stream = {b0, b1};
        r = CRC8_INIT;
        for (i = 15; i >= 0; i--) begin
            fb = r[7] ^ stream[i];
            r  = {r[6:0], 1'b0};
            if (fb) r = r ^ CRC8_POLY;
        end
        return r;
    endfunction

    // CRC-16 over the reply body, byte 0 first, MSB first within a byte
    function automatic logic [15:0] reply_crc16(
        input logic [REPLY_DATA_BYTES-1:0][7:0] body
    );
        logic [15:0] r;
        logic        fb;
        int          i;
        int          k;
        r = CRC16_INIT;
        for (i = 0; i < REPLY_DATA_BYTES; i++) begin
            for (k = 7; k >= 0; k--) begin
                fb = r[15] ^ body[i][k];
                r  = {r[14:0], 1'b0};
                if (fb) r = r ^ CRC16_POLY;
            end
        end
        return r;
    endfunction

endpackage

module fcs_reply_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  logic               i_item_stall,
    input  logic [2:0]         i_operation,
    input  logic [7:0]         i_rx_byte,
    input  logic [2:0]         i_line_error,
    input  logic signed [15:0] i_temperature,
    input  logic [15:0]        i_voltage,
    input  logic               i_button,
    input  logic               i_reply_valid,
    input  logic               i_reply_stall,
    input  logic [7:0]         i_tx_byte,
    input  logic               i_last,
    input  logic [3:0]         i_leds,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    import fcs_pkg::*;
    import fcs_tb_pkg::*;

    logic [3:0]  own_addr;
    logic [7:0]  tmo_ticks;
    t_frame_pos  frame_pos;
    logic [7:0]  first_b;
    logic [7:0]  second_b;
    logic [7:0]  stall_cnt;
    logic [15:0] temp_held;
    logic [15:0] volt_held;
    logic [3:0]  led_st;
    logic        btn_st;
    logic [2:0]  err_code;

    t_reply_byte reply_q[$];
    t_reply_byte head;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_error(input string msg);
        $display("%0t reply check: %s", $time, msg);
        o_fail_count++;
    endtask

    // third byte in: check address and CRC, run the command, queue the reply
    task automatic close_frame(input logic [7:0] crc_in);
        logic [REPLY_DATA_BYTES-1:0][7:0] body;
        logic [15:0]                      crc;
        t_reply_byte                      rb;
        int                               k;
        frame_pos = POS_IDLE;
        if (first_b[3:0] != own_addr || frame_crc8(first_b, second_b) != crc_in) return;
        case (first_b[7:4])
            CMD_REPORT: begin
            end
            CMD_SET_LEDS:    led_st   = second_b[3:0];
            CMD_CLEAR_ERROR: err_code = ERR_NONE;
            default:         err_code = ERR_BAD_COMMAND;
        endcase
        body[0] = temp_held[7:0];
        body[1] = temp_held[15:8];
        body[2] = volt_held[7:0];
        body[3] = volt_held[15:8];
        body[4] = {3'b000, btn_st, led_st};
        body[5] = {5'b00000, err_code};
        crc = reply_crc16(body);
        for (k = 0; k < REPLY_BYTES; k++) begin
            if (k < REPLY_DATA_BYTES) rb.tx_byte = body[k];
            else if (k == REPLY_DATA_BYTES) rb.tx_byte = crc[7:0];
            else rb.tx_byte = crc[15:8];
            rb.last = (k == REPLY_BYTES - 1);
            rb.leds = led_st;
            reply_q.push_back(rb);
        end
    endtask

    task automatic take_item();
        case (t_op'(i_operation))
            OP_RX_BYTE: begin
                case (frame_pos)
                    POS_IDLE: begin
                        first_b   = i_rx_byte;
                        frame_pos = POS_BYTE1;
                    end
                    POS_BYTE1: begin
                        second_b  = i_rx_byte;
                        frame_pos = POS_BYTE2;
                    end
                    default: close_frame(i_rx_byte);
                endcase
            end
            OP_TICK: begin
                if (frame_pos == POS_IDLE) begin
                    stall_cnt = '0;
                end else begin
                    stall_cnt = stall_cnt + 8'd1;
                    if (stall_cnt >= tmo_ticks) begin
                        stall_cnt = '0;
                        frame_pos = POS_IDLE;
                    end
                end
            end
            OP_LINE_ERROR: begin
                frame_pos = POS_IDLE;
                if (i_line_error <= LERR_MAX) err_code = i_line_error + 3'd1;
            end
            OP_SET_TEMP:   temp_held = i_temperature;
            OP_SET_VOLT:   volt_held = i_voltage;
            OP_SET_BUTTON: btn_st    = i_button;
            default: begin
            end
        endcase
    endtask

    task automatic check_reply_byte();
        if (reply_q.size() == 0) begin
            report_error($sformatf("reply byte %02h with nothing pending", i_tx_byte));
        end else begin
            head = reply_q.pop_front();
            if (i_tx_byte !== head.tx_byte)
                report_error($sformatf("tx_byte %02h, want %02h", i_tx_byte, head.tx_byte));
            if (i_last !== head.last)
                report_error($sformatf("last %b, want %b", i_last, head.last));
            if (i_leds !== head.leds)
                report_error($sformatf("leds %h, want %h", i_leds, head.leds));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            own_addr  = DEV_ADDR_RESET;
            tmo_ticks = TIMEOUT_RESET;
            frame_pos = POS_IDLE;
            first_b   = '0;
            second_b  = '0;
            stall_cnt = '0;
            temp_held = '0;
            volt_held = '0;
            led_st    = '0;
            btn_st    = 1'b0;
            err_code  = ERR_NONE;
            reply_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_OWN_ADDR) own_addr = i_cfg_data[3:0];
                else tmo_ticks = i_cfg_data;
            end
            if (i_reply_valid && !i_reply_stall) check_reply_byte();
            if (i_item_valid && !i_item_stall) take_item();
        end
        o_pending = reply_q.size();
    end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

    import fcs_pkg::*;
    import fcs_tb_pkg::*;

    // generous bound on the slowest legal run
    localparam int CYCLE_LIMIT   = 200000;
    // first reply byte shows after the reply queue and the output register; leave margin
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 32;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_operation;
    logic [7:0]         i_rx_byte;
    logic [2:0]         i_line_error;
    logic signed [15:0] i_temperature;
    logic [15:0]        i_voltage;
    logic               i_button;
    logic               o_valid;
    logic               i_stall;
    logic [7:0]         o_tx_byte;
    logic               o_last;
    logic [3:0]         o_leds;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [7:0]         i_cfg_data;

    int fail_count;
    int pending;

    int         cycle_count = 0;
    int         items_sent  = 0;
    int         burst_left  = 0;
    bit         gaps_on     = 1'b1;
    // what the sender believes is configured, used to build frames
    logic [3:0] own_addr    = DEV_ADDR_RESET;
    logic [7:0] tmo_setting = TIMEOUT_RESET;

    // receiver stall pattern state
    int stall_mode = 0;
    int mode_left  = 0;
    int run_left   = 0;
    bit run_high   = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    framed_command_slave DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_rx_byte     (i_rx_byte),
        .i_line_error  (i_line_error),
        .i_temperature (i_temperature),
        .i_voltage     (i_voltage),
        .i_button      (i_button),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tx_byte     (o_tx_byte),
        .o_last        (o_last),
        .o_leds        (o_leds),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    fcs_reply_checker u_reply_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (i_valid),
        .i_item_stall  (o_stall),
        .i_operation   (i_operation),
        .i_rx_byte     (i_rx_byte),
        .i_line_error  (i_line_error),
        .i_temperature (i_temperature),
        .i_voltage     (i_voltage),
        .i_button      (i_button),
        .i_reply_valid (o_valid),
        .i_reply_stall (i_stall),
        .i_tx_byte     (o_tx_byte),
        .i_last        (o_last),
        .i_leds        (o_leds),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // watchdog: a hung handshake or a lost reply ends here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Receiver back-pressure. Modes switch when a random countdown runs out:
    // no stall at all, coin-flip stall, or long stall runs with short releases.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 80);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= 1'($urandom_range(0, 1));
            default: begin
                if (run_left == 0) begin
                    run_high = !run_high;
                    run_left = run_high ? $urandom_range(1, 12) : $urandom_range(1, 4);
                end else begin
                    run_left--;
                end
                i_stall <= run_high;
            end
        endcase
    end

    // Drive one item and hold it until accepted. Called at a falling edge and
    // returns at one. Fields the operation ignores carry random values, so every
    // payload bit toggles. Valid only drops when a gap is actually inserted.
    task automatic send_item(input t_op op, input logic [15:0] val);
        int          gap;
        logic [7:0]  rx;
        logic [2:0]  lerr;
        logic [15:0] temp;
        logic [15:0] volt;
        logic        btn;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        rx   = (op == OP_RX_BYTE)    ? val[7:0] : 8'($urandom);
        lerr = (op == OP_LINE_ERROR) ? val[2:0] : 3'($urandom_range(0, 4));
        temp = (op == OP_SET_TEMP)   ? val      : 16'($urandom);
        volt = (op == OP_SET_VOLT)   ? val      : 16'($urandom);
        btn  = (op == OP_SET_BUTTON) ? val[0]   : 1'($urandom);
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_rx_byte     <= rx;
        i_line_error  <= lerr;
        i_temperature <= temp;
        i_voltage     <= volt;
        i_button      <= btn;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // temperature, voltage or button update, biased toward the extremes
    task automatic sensor_update();
        logic [15:0] v;
        case ($urandom_range(0, 4))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            3: v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        send_item(t_op'($urandom_range(int'(OP_SET_TEMP), int'(OP_SET_BUTTON))), v);
    endtask

    // Three-byte request. A corrupted CRC is xored with a nonzero mask so it
    // never matches. With mix set, sensor updates may land between bytes;
    // they leave the frame position alone.
    task automatic send_frame(input logic [3:0] cmd, input logic [3:0] addr,
                              input logic [7:0] data_b, input logic bad_crc,
                              input logic mix);
        logic [7:0] b0;
        logic [7:0] crc;
        b0  = {cmd, addr};
        crc = frame_crc8(b0, data_b);
        if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
        send_item(OP_RX_BYTE, {8'h00, b0});
        if (mix && $urandom_range(0, 4) == 0) sensor_update();
        send_item(OP_RX_BYTE, {8'h00, data_b});
        if (mix && $urandom_range(0, 4) == 0) sensor_update();
        send_item(OP_RX_BYTE, {8'h00, crc});
    endtask

    function automatic logic [3:0] pick_cmd();
        case ($urandom_range(0, 9))
            0, 1, 2: return CMD_REPORT;
            3, 4, 5: return CMD_SET_LEDS;
            6, 7:    return CMD_CLEAR_ERROR;
            default: return 4'($urandom);
        endcase
    endfunction

    // One random scenario. Most often a well-formed frame with random content;
    // the rest is bad frames, partial frames that get dropped, and side events.
    // Every scenario leaves the frame position back at idle so the next
    // good frame stays aligned.
    task automatic random_step();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            send_frame(pick_cmd(), own_addr, 8'($urandom), 1'b0, 1'b1);
        end else if (sel < 47) begin
            // someone else's address
            send_frame(pick_cmd(), own_addr ^ 4'($urandom_range(1, 15)), 8'($urandom),
                       1'b0, 1'b1);
        end else if (sel < 54) begin
            send_frame(pick_cmd(), own_addr, 8'($urandom), 1'b1, 1'b1);
        end else if (sel < 66) begin
            // partial frame, dropped by tick timeout or by a line error
            n = $urandom_range(1, 2);
            repeat (n) send_item(OP_RX_BYTE, 16'($urandom));
            if (tmo_setting <= 30 && $urandom_range(0, 1) == 1)
                repeat (tmo_setting) send_item(OP_TICK, 16'h0000);
            else
                send_item(OP_LINE_ERROR, 16'($urandom_range(0, 4)));
        end else if (sel < 78) begin
            sensor_update();
        end else if (sel < 90) begin
            repeat ($urandom_range(1, 3)) send_item(OP_TICK, 16'h0000);
        end else begin
            send_item(OP_LINE_ERROR, 16'($urandom_range(0, 4)));
        end
    endtask

    // both registers, back to back; upper nibble of the address data is junk
    task automatic write_config(input logic [3:0] addr, input logic [7:0] tmo);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_OWN_ADDR;
        i_cfg_data  <= {4'($urandom), addr};
        @(negedge i_clk);
        i_cfg_index <= CFG_TIMEOUT_TICKS;
        i_cfg_data  <= tmo;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        own_addr    = addr;
        tmo_setting = tmo;
    endtask

    // stop sending and wait for every pending reply byte, then wait out the SETTLE_CYCLES margin
    task automatic settle();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int         phase;
        int         target;
        logic [3:0] addr;
        logic [7:0] tmo;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_operation   = OP_RX_BYTE;
        i_rx_byte     = '0;
        i_line_error  = '0;
        i_temperature = '0;
        i_voltage     = '0;
        i_button      = 1'b0;
        i_stall       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_OWN_ADDR;
        i_cfg_data    = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset configuration (address 1, timeout 10).
        // Sensor extremes first so the replies carry them.
        send_item(OP_SET_TEMP, 16'h8000);
        send_item(OP_SET_VOLT, 16'hFFFF);
        send_item(OP_SET_BUTTON, 16'h0001);
        // all LEDs on
        send_frame(CMD_SET_LEDS, own_addr, {4'($urandom), 4'hF}, 1'b0, 1'b0);
        // clear error, then raise the highest line error code
        send_frame(CMD_CLEAR_ERROR, own_addr, 8'($urandom), 1'b0, 1'b0);
        send_item(OP_LINE_ERROR, 16'h0004);
        send_frame(CMD_REPORT, own_addr, 8'($urandom), 1'b0, 1'b0);
        // unknown command still replies, with the bad-command error
        send_frame(4'h0, own_addr, 8'($urandom), 1'b0, 1'b0);
        // wrong address, then wrong CRC: both silently dropped
        send_frame(CMD_REPORT, own_addr ^ 4'h8, 8'($urandom), 1'b0, 1'b0);
        send_frame(CMD_REPORT, own_addr, 8'($urandom), 1'b1, 1'b0);
        // line error in mid-frame drops the partial frame
        send_item(OP_RX_BYTE, {8'h00, CMD_REPORT, own_addr});
        send_item(OP_LINE_ERROR, 16'h0000);

        // Random phases, each under its own configuration. The first two
        // hit the register extremes. Every phase starts from a drained block,
        // which doubles as the sender holding off until all replies are back.
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    addr = 4'h0;
                    tmo  = 8'd1;
                end
                1: begin
                    addr = 4'hF;
                    tmo  = 8'd255;
                end
                2: begin
                    addr = 4'($urandom);
                    tmo  = 8'd2;
                end
                default: begin
                    addr = 4'($urandom);
                    tmo  = 8'($urandom_range(1, 40));
                end
            endcase
            write_config(addr, tmo);
            // one phase runs the sender with no gaps at all
            gaps_on = (phase != 2);
            target  = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_step();
        end

        settle();
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
